// ===== rtl/fpf_pkg.sv =====
`default_nettype none

package fpf_pkg;

    // fraction bits of the fixed point format
    localparam int FRAC_BITS_DEF = 16;

    // long division: quotient bits kept, then clamp
    localparam int DIV_QBITS = 62;
    localparam int DIV_LAT   = DIV_QBITS + 2;
    localparam int NUM_W     = 94;

    localparam logic [DIV_QBITS-1:0] CLAMP_MAG = DIV_QBITS'(1) << 61;

    // ln 2 with 28 fraction bits
    localparam logic [27:0] LN2_Q28 = 28'd186065279;

endpackage

`default_nettype wire

// ===== rtl/fpf_div.sv =====
`default_nettype none

module fpf_div #(
    parameter int NUM_W = fpf_pkg::NUM_W,
    parameter int DEN_W = 64
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [NUM_W-1:0]        num_i,
    input  logic [DEN_W-1:0]        den_i,
    input  logic                    neg_i,
    output logic signed [63:0]      quo_o
);
    import fpf_pkg::*;

    logic [NUM_W-1:0]     hi;
    logic                 ovr;
    logic [DEN_W-1:0]     rem_reg [DIV_QBITS+1];
    logic [DIV_QBITS-1:0] sh_reg  [DIV_QBITS+1];
    logic [DEN_W-1:0]     den_reg [DIV_QBITS+1];
    logic                 ovr_reg [DIV_QBITS+1];
    logic                 neg_reg [DIV_QBITS+1];
    logic [DEN_W:0]       cat     [DIV_QBITS];
    logic                 ge      [DIV_QBITS];
    logic [DEN_W-1:0]     rem_next [DIV_QBITS];
    logic [DIV_QBITS-1:0] sh_next  [DIV_QBITS];
    logic [DIV_QBITS-1:0] q;
    logic signed [63:0]   quo_reg;

    // quotient of 2^62 or more is flagged on entry and saturates at the output
    assign hi  = NUM_W'(num_i >> DIV_QBITS);
    assign ovr = ({DEN_W'(0), hi} >= {NUM_W'(0), den_i});

    // one quotient bit per stage, numerator bits shift out as quotient bits shift in
    always_comb begin
        for (int j = 0; j < DIV_QBITS; j++) begin
            cat[j] = {rem_reg[j], sh_reg[j][DIV_QBITS-1]};
            ge[j]  = (cat[j] >= {1'b0, den_reg[j]});
            rem_next[j] = ge[j] ? DEN_W'(cat[j] - {1'b0, den_reg[j]}) : DEN_W'(cat[j]);
            sh_next[j]  = {sh_reg[j][DIV_QBITS-2:0], ge[j]};
        end
    end

    always_comb begin
        q = sh_reg[DIV_QBITS];
        if (ovr_reg[DIV_QBITS] || (q > CLAMP_MAG)) begin
            q = CLAMP_MAG;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= DEN_W'(hi);
            sh_reg[0]  <= num_i[DIV_QBITS-1:0];
            den_reg[0] <= den_i;
            ovr_reg[0] <= ovr;
            neg_reg[0] <= neg_i;
            for (int j = 0; j < DIV_QBITS; j++) begin
                rem_reg[j+1] <= rem_next[j];
                sh_reg[j+1]  <= sh_next[j];
                den_reg[j+1] <= den_reg[j];
                ovr_reg[j+1] <= ovr_reg[j];
                neg_reg[j+1] <= neg_reg[j];
            end
            quo_reg <= neg_reg[DIV_QBITS] ? -$signed(64'(q)) : $signed(64'(q));
        end
    end

    assign quo_o = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/fluid_pair_force.sv =====
// fluid_pair_force: one pair per cycle unless the result side stalls, fully pipelined
// stages: 4 front stages, two 64-stage dividers in series and 2 output stages;
// the square root and log run beside the first divider
// throughput: one item per cycle; a stall on the result side freezes the whole pipeline
// reset: aresetn synchronous active low clears the valid bits only; no clearing pass
`default_nettype none

module fluid_pair_force #(
    parameter int FRAC_BITS = fpf_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_disp_x,
    input  logic signed [31:0] s_disp_y,
    input  logic signed [31:0] s_disp_z,
    input  logic signed [31:0] s_cohesion_a,
    input  logic signed [31:0] s_cohesion_b,
    input  logic signed [31:0] s_repulsion_a,
    input  logic signed [31:0] s_repulsion_b,
    input  logic signed [31:0] s_friction_a,
    input  logic signed [31:0] s_velocity_x,
    input  logic signed [31:0] s_velocity_y,
    input  logic signed [31:0] s_velocity_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_force_x,
    output logic signed [31:0] m_force_y,
    output logic signed [31:0] m_force_z,
    output logic signed [31:0] m_pair_energy,
    output logic               m_zero_distance
);
    import fpf_pkg::*;

    localparam int FRONT_STG = 4;
    localparam int SQ_STG    = 32;
    localparam int LG_STG    = 28;
    localparam int LAT       = FRONT_STG + 2 * DIV_LAT + 2;
    localparam int R_DLY     = 1 + DIV_LAT - SQ_STG;
    localparam int K_DLY     = 3 + DIV_LAT;
    localparam int FZ_DLY    = 1 + 2 * DIV_LAT;
    localparam int E1_DLY    = DIV_LAT - 1;
    localparam int LN_W      = FRAC_BITS + 5;
    localparam int LN_SH     = 56 - FRAC_BITS;

    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        return x[31] ? unsigned'(-x) : unsigned'(x);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'h8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

    logic            adv;
    logic [LAT-1:0]  vld_reg;
    logic signed [31:0] din [3];
    logic signed [31:0] vin [3];

    assign din[0] = s_disp_x;
    assign din[1] = s_disp_y;
    assign din[2] = s_disp_z;
    assign vin[0] = s_velocity_x;
    assign vin[1] = s_velocity_y;
    assign vin[2] = s_velocity_z;

    assign m_valid = vld_reg[LAT-1];
    assign adv     = !vld_reg[LAT-1] || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    // stage 1: magnitudes and signs
    logic [31:0] dm1_reg [3];
    logic        dn1_reg [3];
    logic [31:0] vm1_reg [3];
    logic        vn1_reg [3];
    logic [31:0] kcam1_reg, kcbm1_reg, kram1_reg, krbm1_reg, kfm1_reg;
    logic        kcan1_reg, kcbn1_reg, kran1_reg, krbn1_reg, kfn1_reg;

    // stage 2: products
    logic [63:0] sq2_reg  [3];
    logic [63:0] frm2_reg [3];
    logic        frn2_reg [3];
    logic [31:0] dm2_reg  [3];
    logic        dn2_reg  [3];
    logic [63:0] pcm2_reg, prm2_reg;
    logic        pcn2_reg, prn2_reg;

    // stage 3: squared length, partial products of the numerators
    logic [63:0]        r2_3_reg;
    logic [63:0]        pcl3_reg [3];
    logic [63:0]        prl3_reg [3];
    logic [62:0]        pch3_reg [3];
    logic [62:0]        prh3_reg [3];
    logic               cohn3_reg [3];
    logic               tn3_reg   [3];
    logic signed [63:0] fr3_reg   [3];
    logic               zero3_reg;
    logic [63:0]        frs [3];

    // stage 4: full numerators
    logic [NUM_W-1:0] ncoh4_reg [3];
    logic [NUM_W-1:0] nt4_reg   [3];
    logic [63:0]      r2_4_reg;
    logic             cohn4_reg [3];
    logic             tn4_reg   [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            frs[k] = 64'(frm2_reg[k] >> FRAC_BITS);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                dm1_reg[k] <= mag32(din[k]);
                dn1_reg[k] <= din[k][31];
                vm1_reg[k] <= mag32(vin[k]);
                vn1_reg[k] <= vin[k][31];
            end
            kcam1_reg <= mag32(s_cohesion_a);
            kcbm1_reg <= mag32(s_cohesion_b);
            kram1_reg <= mag32(s_repulsion_a);
            krbm1_reg <= mag32(s_repulsion_b);
            kfm1_reg  <= mag32(s_friction_a);
            kcan1_reg <= s_cohesion_a[31];
            kcbn1_reg <= s_cohesion_b[31];
            kran1_reg <= s_repulsion_a[31];
            krbn1_reg <= s_repulsion_b[31];
            kfn1_reg  <= s_friction_a[31];

            for (int k = 0; k < 3; k++) begin
                sq2_reg[k]  <= dm1_reg[k] * dm1_reg[k];
                frm2_reg[k] <= vm1_reg[k] * kfm1_reg;
                frn2_reg[k] <= !(vn1_reg[k] ^ kfn1_reg);
                dm2_reg[k]  <= dm1_reg[k];
                dn2_reg[k]  <= dn1_reg[k];
            end
            pcm2_reg <= kcam1_reg * kcbm1_reg;
            prm2_reg <= kram1_reg * krbm1_reg;
            pcn2_reg <= kcan1_reg ^ kcbn1_reg;
            prn2_reg <= kran1_reg ^ krbn1_reg;

            r2_3_reg  <= sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
            zero3_reg <= ((sq2_reg[0] | sq2_reg[1] | sq2_reg[2]) == 64'd0);
            for (int k = 0; k < 3; k++) begin
                pcl3_reg[k]  <= pcm2_reg[31:0] * dm2_reg[k];
                pch3_reg[k]  <= pcm2_reg[62:32] * dm2_reg[k];
                prl3_reg[k]  <= prm2_reg[31:0] * dm2_reg[k];
                prh3_reg[k]  <= prm2_reg[62:32] * dm2_reg[k];
                cohn3_reg[k] <= !(pcn2_reg ^ dn2_reg[k]);
                tn3_reg[k]   <= prn2_reg ^ dn2_reg[k];
                fr3_reg[k]   <= frn2_reg[k] ? -$signed(frs[k]) : $signed(frs[k]);
            end

            r2_4_reg <= r2_3_reg;
            for (int k = 0; k < 3; k++) begin
                ncoh4_reg[k] <= NUM_W'({pch3_reg[k], 32'd0}) + NUM_W'(pcl3_reg[k]);
                nt4_reg[k]   <= NUM_W'({prh3_reg[k], 32'd0}) + NUM_W'(prl3_reg[k]);
                cohn4_reg[k] <= cohn3_reg[k];
                tn4_reg[k]   <= tn3_reg[k];
            end
        end
    end

    // side data carried to where it is consumed
    logic signed [63:0] fr_dly_reg   [FZ_DLY][3];
    logic               zero_dly_reg [FZ_DLY];
    logic [31:0]        kcam_dly_reg [K_DLY];
    logic               kcan_dly_reg [K_DLY];
    logic [31:0]        kram_dly_reg [K_DLY];
    logic               kran_dly_reg [K_DLY];

    always_ff @(posedge aclk) begin
        if (adv) begin
            fr_dly_reg[0]   <= fr3_reg;
            zero_dly_reg[0] <= zero3_reg;
            for (int i = 1; i < FZ_DLY; i++) begin
                fr_dly_reg[i]   <= fr_dly_reg[i-1];
                zero_dly_reg[i] <= zero_dly_reg[i-1];
            end
            kcam_dly_reg[0] <= kcam1_reg;
            kcan_dly_reg[0] <= kcan1_reg;
            kram_dly_reg[0] <= kram1_reg;
            kran_dly_reg[0] <= kran1_reg;
            for (int i = 1; i < K_DLY; i++) begin
                kcam_dly_reg[i] <= kcam_dly_reg[i-1];
                kcan_dly_reg[i] <= kcan_dly_reg[i-1];
                kram_dly_reg[i] <= kram_dly_reg[i-1];
                kran_dly_reg[i] <= kran_dly_reg[i-1];
            end
        end
    end

    // integer square root, one result bit per stage
    logic [63:0] sq_rem_reg  [SQ_STG];
    logic [63:0] sq_res_reg  [SQ_STG];
    logic [63:0] sq_rem_in   [SQ_STG];
    logic [63:0] sq_res_in   [SQ_STG];
    logic [63:0] sq_try      [SQ_STG];
    logic [63:0] sq_rem_next [SQ_STG];
    logic [63:0] sq_res_next [SQ_STG];

    always_comb begin
        sq_rem_in[0] = r2_3_reg;
        sq_res_in[0] = 64'd0;
        for (int i = 1; i < SQ_STG; i++) begin
            sq_rem_in[i] = sq_rem_reg[i-1];
            sq_res_in[i] = sq_res_reg[i-1];
        end
        for (int i = 0; i < SQ_STG; i++) begin
            sq_try[i] = sq_res_in[i] + (64'd1 << (62 - 2 * i));
            if (sq_rem_in[i] >= sq_try[i]) begin
                sq_rem_next[i] = sq_rem_in[i] - sq_try[i];
                sq_res_next[i] = (sq_res_in[i] >> 1) + (64'd1 << (62 - 2 * i));
            end else begin
                sq_rem_next[i] = sq_rem_in[i];
                sq_res_next[i] = sq_res_in[i] >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < SQ_STG; i++) begin
                sq_rem_reg[i] <= sq_rem_next[i];
                sq_res_reg[i] <= sq_res_next[i];
            end
        end
    end

    logic [31:0] r_dly_reg [R_DLY];

    always_ff @(posedge aclk) begin
        if (adv) begin
            r_dly_reg[0] <= sq_res_reg[SQ_STG-1][31:0];
            for (int i = 1; i < R_DLY; i++) begin
                r_dly_reg[i] <= r_dly_reg[i-1];
            end
        end
    end

    // ln r: leading one, normalize to [1,2), log2 by repeated squaring, scale by ln 2
    logic [4:0]          lg_msb_next;
    logic [4:0]          lg_msb1_reg;
    logic [28:0]         lg_m2_reg;
    logic [4:0]          lg_msb2_reg;
    logic [28:0]         lg_m_reg    [LG_STG];
    logic [27:0]         lg_frac_reg [LG_STG];
    logic [4:0]          lg_msb_reg  [LG_STG];
    logic [28:0]         lg_m_in     [LG_STG];
    logic [27:0]         lg_frac_in  [LG_STG];
    logic [57:0]         lg_p        [LG_STG];
    logic [28:0]         lg_m_next   [LG_STG];
    logic [27:0]         lg_frac_next [LG_STG];
    logic signed [6:0]   lg_exp;
    logic signed [34:0]  lg_l2;
    logic [33:0]         lg_mag_reg;
    logic                lg_neg_reg;
    logic [61:0]         lg_prod_reg;
    logic                lg_pneg_reg;
    logic [LN_W-1:0]     ln_mag;
    logic [32+LN_W-1:0]  e1p_reg;
    logic                e1n_reg;
    logic [63:0]         e1s;
    logic signed [63:0]  e1_reg;
    logic signed [63:0]  e1_dly_reg [E1_DLY];

    always_comb begin
        lg_msb_next = '0;
        for (int i = 0; i < 32; i++) begin
            if (sq_res_reg[SQ_STG-1][i]) begin
                lg_msb_next = 5'(i);
            end
        end
    end

    always_comb begin
        lg_m_in[0]    = lg_m2_reg;
        lg_frac_in[0] = '0;
        for (int j = 1; j < LG_STG; j++) begin
            lg_m_in[j]    = lg_m_reg[j-1];
            lg_frac_in[j] = lg_frac_reg[j-1];
        end
        for (int j = 0; j < LG_STG; j++) begin
            lg_p[j] = lg_m_in[j] * lg_m_in[j];
            if (lg_p[j][57]) begin
                lg_m_next[j]    = lg_p[j][57:29];
                lg_frac_next[j] = {lg_frac_in[j][26:0], 1'b1};
            end else begin
                lg_m_next[j]    = lg_p[j][56:28];
                lg_frac_next[j] = {lg_frac_in[j][26:0], 1'b0};
            end
        end
    end

    assign lg_exp = $signed({2'b00, lg_msb_reg[LG_STG-1]}) - 7'(FRAC_BITS);
    assign lg_l2  = {lg_exp, lg_frac_reg[LG_STG-1]};
    assign ln_mag = LN_W'(lg_prod_reg >> LN_SH);
    assign e1s    = 64'(e1p_reg >> FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (adv) begin
            lg_msb1_reg <= lg_msb_next;
            lg_m2_reg   <= 29'((64'(r_dly_reg[0]) << 28) >> lg_msb1_reg);
            lg_msb2_reg <= lg_msb1_reg;
            lg_msb_reg[0] <= lg_msb2_reg;
            for (int j = 0; j < LG_STG; j++) begin
                lg_m_reg[j]    <= lg_m_next[j];
                lg_frac_reg[j] <= lg_frac_next[j];
            end
            for (int j = 1; j < LG_STG; j++) begin
                lg_msb_reg[j] <= lg_msb_reg[j-1];
            end
            lg_neg_reg  <= lg_l2[34];
            lg_mag_reg  <= lg_l2[34] ? 34'(-lg_l2) : 34'(lg_l2);
            lg_prod_reg <= lg_mag_reg * LN2_Q28;
            lg_pneg_reg <= lg_neg_reg;
            e1p_reg <= kcam_dly_reg[K_DLY-2] * ln_mag;
            e1n_reg <= kcan_dly_reg[K_DLY-2] ^ lg_pneg_reg;
            e1_reg  <= e1n_reg ? -$signed(e1s) : $signed(e1s);
            e1_dly_reg[0] <= e1_reg;
            for (int i = 1; i < E1_DLY; i++) begin
                e1_dly_reg[i] <= e1_dly_reg[i-1];
            end
        end
    end

    // dividers
    logic signed [63:0] coh_q [3];
    logic signed [63:0] t_q   [3];
    logic signed [63:0] rep_q [3];
    logic [63:0]        t_mag [3];
    logic signed [63:0] e2_q;
    logic signed [63:0] coh_dly_reg [DIV_LAT][3];

    for (genvar k = 0; k < 3; k++) begin : g_axis
        assign t_mag[k] = t_q[k][63] ? unsigned'(-t_q[k]) : unsigned'(t_q[k]);

        fpf_div #(.NUM_W(NUM_W), .DEN_W(64)) u_coh_div (
            .aclk  (aclk),
            .en    (adv),
            .num_i (ncoh4_reg[k]),
            .den_i (r2_4_reg),
            .neg_i (cohn4_reg[k]),
            .quo_o (coh_q[k])
        );

        fpf_div #(.NUM_W(NUM_W), .DEN_W(64)) u_t_div (
            .aclk  (aclk),
            .en    (adv),
            .num_i (nt4_reg[k]),
            .den_i (r2_4_reg),
            .neg_i (tn4_reg[k]),
            .quo_o (t_q[k])
        );

        fpf_div #(.NUM_W(NUM_W), .DEN_W(32)) u_rep_div (
            .aclk  (aclk),
            .en    (adv),
            .num_i (NUM_W'(t_mag[k]) << FRAC_BITS),
            .den_i (r_dly_reg[R_DLY-1]),
            .neg_i (t_q[k][63]),
            .quo_o (rep_q[k])
        );
    end

    fpf_div #(.NUM_W(NUM_W), .DEN_W(32)) u_e2_div (
        .aclk  (aclk),
        .en    (adv),
        .num_i (NUM_W'(kram_dly_reg[K_DLY-1]) << FRAC_BITS),
        .den_i (r_dly_reg[R_DLY-1]),
        .neg_i (kran_dly_reg[K_DLY-1]),
        .quo_o (e2_q)
    );

    // sums, then saturation into the output register
    logic signed [63:0] fsum_reg [3];
    logic signed [63:0] esum_reg;
    logic               zsum_reg;
    logic [31:0]        force_reg [3];
    logic [31:0]        energy_reg;
    logic               zflag_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            coh_dly_reg[0] <= coh_q;
            for (int i = 1; i < DIV_LAT; i++) begin
                coh_dly_reg[i] <= coh_dly_reg[i-1];
            end
            for (int k = 0; k < 3; k++) begin
                fsum_reg[k] <= coh_dly_reg[DIV_LAT-1][k] + rep_q[k]
                               + fr_dly_reg[FZ_DLY-1][k];
            end
            esum_reg <= -(e1_dly_reg[E1_DLY-1] + e2_q);
            zsum_reg <= zero_dly_reg[FZ_DLY-1];
            for (int k = 0; k < 3; k++) begin
                force_reg[k] <= zsum_reg ? 32'h7FFF_FFFF : sat32(fsum_reg[k]);
            end
            energy_reg <= zsum_reg ? 32'h7FFF_FFFF : sat32(esum_reg);
            zflag_reg  <= zsum_reg;
        end
    end

    assign m_force_x       = $signed(force_reg[0]);
    assign m_force_y       = $signed(force_reg[1]);
    assign m_force_z       = $signed(force_reg[2]);
    assign m_pair_energy   = $signed(energy_reg);
    assign m_zero_distance = zflag_reg;

    // zero distance forces all results to the positive limit
    a_zero_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_distance |-> m_force_x == 32'sh7FFF_FFFF
            && m_force_y == 32'sh7FFF_FFFF && m_force_z == 32'sh7FFF_FFFF
            && m_pair_energy == 32'sh7FFF_FFFF)
        else $error("zero distance result not saturated");

    // a stalled pipeline keeps every valid bit
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

    // an input transfer always lands in the first stage
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted item lost at entry");

    // nonzero squared length gives a root of at least one
    a_root: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[FRONT_STG-2+SQ_STG] && !zero_dly_reg[SQ_STG-1]
            |-> sq_res_reg[SQ_STG-1] != 64'd0)
        else $error("square root of nonzero length is zero");

    // the first cohesion divider result never exceeds the clamp
    a_coh_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[FRONT_STG+DIV_LAT-1] |-> coh_q[0] <= $signed(64'(CLAMP_MAG))
            && coh_q[0] >= -$signed(64'(CLAMP_MAG)))
        else $error("cohesion term beyond clamp");

endmodule

`default_nettype wire

// ===== tb/fluid_pair_force_tb.sv =====
`timescale 1ns / 1ps

module fluid_pair_force_tb;

    localparam int FRAC = fpf_pkg::FRAC_BITS_DEF;
    localparam int LATENCY = 134;

    typedef struct packed {
        int dx, dy, dz;
        int kca, kcb, kra, krb, kf;
        int vx, vy, vz;
    } pair_t;

    typedef struct packed {
        int fx, fy, fz, energy;
        logic zero_dist;
    } force_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_disp_x = '0, s_disp_y = '0, s_disp_z = '0;
    logic signed [31:0] s_cohesion_a = '0, s_cohesion_b = '0;
    logic signed [31:0] s_repulsion_a = '0, s_repulsion_b = '0;
    logic signed [31:0] s_friction_a = '0;
    logic signed [31:0] s_velocity_x = '0, s_velocity_y = '0, s_velocity_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_force_x, m_force_y, m_force_z, m_pair_energy;
    logic m_zero_distance;

    force_t pending_forces[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_req = 1'b0;
    int hold_left = 0;

    fluid_pair_force dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_disp_x(s_disp_x), .s_disp_y(s_disp_y), .s_disp_z(s_disp_z),
        .s_cohesion_a(s_cohesion_a), .s_cohesion_b(s_cohesion_b),
        .s_repulsion_a(s_repulsion_a), .s_repulsion_b(s_repulsion_b),
        .s_friction_a(s_friction_a),
        .s_velocity_x(s_velocity_x), .s_velocity_y(s_velocity_y),
        .s_velocity_z(s_velocity_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_force_x(m_force_x), .m_force_y(m_force_y), .m_force_z(m_force_z),
        .m_pair_energy(m_pair_energy), .m_zero_distance(m_zero_distance)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // a*b/c exact, truncated toward zero, clamped to +-2^61
    function automatic longint mul_div_clamp(longint a, longint b, logic [63:0] c);
        logic [63:0] ua, ub;
        logic [127:0] prod, q;
        logic neg;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? 64'(-a) : 64'(a);
        ub = (b < 0) ? 64'(-b) : 64'(b);
        prod = {64'd0, ua} * {64'd0, ub};
        if (c == 0) begin
            q = (prod != 0) ? (128'd1 << 61) : 128'd0;
        end else begin
            q = prod / {64'd0, c};
            if (q > (128'd1 << 61)) q = 128'd1 << 61;
        end
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // natural log of a fixed point value via log2 by repeated squaring
    function automatic longint ln_q(logic [63:0] r);
        int msb;
        logic [63:0] m;
        longint frac, l2;
        msb = 0;
        frac = 0;
        for (int i = 0; i < 64; i++) if (r[i]) msb = i;
        m = (msb >= 28) ? (r >> (msb - 28)) : (r << (28 - msb));
        for (int i = 27; i >= 0; i--) begin
            m = (m * m) >> 28;
            if (m >= (64'd1 << 29)) begin
                m = m >> 1;
                frac = frac | (64'sd1 << i);
            end
        end
        l2 = longint'(msb - FRAC) * (64'sd1 << 28) + frac;
        return mul_div_clamp(l2, longint'(fpf_pkg::LN2_Q28), 64'd1 << (56 - FRAC));
    endfunction

    function automatic int sat32(longint v);
        if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
        if (v < -64'sh80000000) return 32'sh80000000;
        return int'(v);
    endfunction

    function automatic force_t predict_pair(pair_t p);
        force_t f;
        longint d[3], v[3], pc, pr, coh, t, rep, fr, e1, e2;
        logic [63:0] r2, r, mag, one;
        int fo[3];
        one = 64'd1 << FRAC;
        d[0] = p.dx; d[1] = p.dy; d[2] = p.dz;
        v[0] = p.vx; v[1] = p.vy; v[2] = p.vz;
        r2 = 0;
        for (int k = 0; k < 3; k++) begin
            mag = (d[k] < 0) ? 64'(-d[k]) : 64'(d[k]);
            r2 = r2 + mag * mag;
        end
        if (r2 == 0) begin
            f.fx = 32'sh7FFFFFFF; f.fy = 32'sh7FFFFFFF; f.fz = 32'sh7FFFFFFF;
            f.energy = 32'sh7FFFFFFF;
            f.zero_dist = 1'b1;
            return f;
        end
        r = floor_sqrt(r2);
        pc = longint'(p.kca) * longint'(p.kcb);
        pr = longint'(p.kra) * longint'(p.krb);
        for (int k = 0; k < 3; k++) begin
            coh = -mul_div_clamp(pc, d[k], r2);
            t = mul_div_clamp(pr, d[k], r2);
            rep = mul_div_clamp(t, longint'(one), r);
            fr = -mul_div_clamp(v[k], longint'(p.kf), one);
            fo[k] = sat32(coh + rep + fr);
        end
        f.fx = fo[0]; f.fy = fo[1]; f.fz = fo[2];
        e1 = mul_div_clamp(longint'(p.kca), ln_q(r), one);
        e2 = mul_div_clamp(longint'(p.kra), longint'(one), r);
        f.energy = sat32(-(e1 + e2));
        f.zero_dist = 1'b0;
        return f;
    endfunction

    task automatic report(string what, int got, int want);
        errors++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    task automatic send_pair(pair_t p);
        int gap;
        gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_disp_x <= p.dx; s_disp_y <= p.dy; s_disp_z <= p.dz;
        s_cohesion_a <= p.kca; s_cohesion_b <= p.kcb;
        s_repulsion_a <= p.kra; s_repulsion_b <= p.krb;
        s_friction_a <= p.kf;
        s_velocity_x <= p.vx; s_velocity_y <= p.vy; s_velocity_z <= p.vz;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_forces.push_back(predict_pair(p));
    endtask

    // result side: check each transfer, then choose ready for the next edge
    always @(posedge aclk) begin
        force_t w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_forces.size() == 0) begin
                report("unexpected result", m_force_x, 0);
            end else begin
                w = pending_forces.pop_front();
                if (m_force_x !== w.fx) report("force_x", m_force_x, w.fx);
                if (m_force_y !== w.fy) report("force_y", m_force_y, w.fy);
                if (m_force_z !== w.fz) report("force_z", m_force_z, w.fz);
                if (m_pair_energy !== w.energy)
                    report("pair_energy", m_pair_energy, w.energy);
                if (m_zero_distance !== w.zero_dist)
                    report("zero_distance", m_zero_distance, w.zero_dist);
            end
        end
        if (hold_left > 0) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
        else if (hold_req) hold_left <= 400;
    end

    function automatic int small_val(int bits);
        return $signed($urandom) >>> (31 - bits);
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        int kind;
        kind = $urandom_range(0, 9);
        if (kind <= 1) begin
            p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom};
        end else begin
            p.dx = small_val(20); p.dy = small_val(20); p.dz = small_val(20);
            p.kca = small_val(18); p.kcb = small_val(18);
            p.kra = small_val(18); p.krb = small_val(18);
            p.kf = small_val(17);
            p.vx = small_val(20); p.vy = small_val(20); p.vz = small_val(20);
        end
        if (kind == 2) begin
            p.dx = 0; p.dy = 0; p.dz = 0;
        end
        return p;
    endfunction

    task automatic test_directed();
        pair_t p;
        int mx, mn;
        mx = 32'sh7FFFFFFF;
        mn = 32'sh80000000;
        send_idle_pct = 0; recv_stall_pct = 0;
        // zero distance, with and without other content
        send_pair('0);
        send_pair('{0, 0, 0, mx, mn, mx, mn, mx, mx, mn, 1});
        // all maximum, all minimum, alternating maximum and minimum
        send_pair('{mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx});
        send_pair('{mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn});
        send_pair('{mx, mn, mx, mn, mx, mn, mx, mn, mx, mn, mx});
        // smallest nonzero distance and unit distance
        send_pair('{1, 0, 0, 65536, 65536, 65536, 65536, 65536, 1, -1, 0});
        send_pair('{0, -1, 0, mx, mx, mx, mx, 0, 0, 0, 0});
        send_pair('{65536, 0, 0, 65536, 65536, 65536, 65536, 65536, 65536, 0, 0});
        send_pair('{0, 0, -65536, 131072, 32768, 196608, 16384, 6553, 1000, -2000, 3000});
        // huge terms that clamp and cancel
        send_pair('{1, 1, 1, mx, mx, mx, mx, 0, 0, 0, 0});
        send_pair('{-1, 1, -1, mn, mx, mn, mn, mn, mn, mx, mn});
        // zero coefficients with pure friction, then a mixed-sign case
        send_pair('{65536, 65536, 65536, 0, 0, 0, 0, mx, mx, mn, 12345});
        send_pair('{mn, 0, 0, -65536, 65536, -65536, -65536, -1, 65536, 65536, 65536});
        for (int i = 0; i < 8; i++) begin
            p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom};
            send_pair(p);
        end
    endtask

    task automatic test_random(int n, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) send_pair(random_pair());
    endtask

    // long receiver hold-off so the pipeline fills and stalls the input
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        s_valid <= 1'b0;
        hold_req = 1'b1;
        while (hold_left == 0) @(posedge aclk);
        hold_req = 1'b0;
        for (int i = 0; i < 250; i++) send_pair(random_pair());
    endtask

    initial begin
        int guard;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(150, 0, 0);
        test_random(150, 51, 0);
        test_random(150, 0, 51);
        test_random(150, 23, 23);
        test_backpressure();
        s_valid <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        guard = 0;
        while (pending_forces.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (LATENCY + 16) @(posedge aclk);
        if (pending_forces.size() != 0)
            report("results still missing", pending_forces.size(), 0);
        if (errors == 0) begin
            $display("fluid_pair_force_tb OK");
        end else begin
            $display("fluid_pair_force_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("fluid_pair_force_tb NOT OK");
        $finish;
    end

endmodule

// ===== fluid_pair_force.f =====
rtl/fpf_pkg.sv
rtl/fpf_div.sv
rtl/fluid_pair_force.sv
tb/fluid_pair_force_tb.sv
